### hdl/ipdal_pkg.sv
// ----------------------------------------------------------------------------
// ipdal_pkg
// Types, codes and helpers shared by the dual IPv4 allowlist table.
// ----------------------------------------------------------------------------
package ipdal_pkg;

  localparam int ADDR_W   = 32;
  localparam int IDX_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDITS_ENABLED      = 2'd0,
    CFG_ADMIN_PRIVATE_ONLY = 2'd1
  } cfg_reg_t;

  localparam logic LIST_ADMIN    = 1'b0;
  localparam logic LIST_CONSUMER = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              list_select;
    logic [ADDR_W-1:0] address;
    logic [IDX_W-1:0]  entry_index;
  } in_beat_t;

  typedef struct packed {
    logic               success;
    logic [COUNT_W-1:0] entry_count;
    logic [ADDR_W-1:0]  entry_value;
  } out_beat_t;

  // Per-row command broadcast to every cell
  typedef struct packed {
    logic              cmp_en;
    logic              add_en;
    logic              rm_en;
    logic              rd_en;
    logic [ADDR_W-1:0] address;
  } cell_ctl_t;

  // Low byte is the first octet
  function automatic logic addr_is_private(input logic [ADDR_W-1:0] ip);
    logic [7:0] a;
    logic [7:0] b;
    a = ip[7:0];
    b = ip[15:8];
    return (a == 8'd10) || (a == 8'd127) ||
           ((a == 8'd169) && (b == 8'd254)) ||
           ((a == 8'd172) && (b >= 8'd16) && (b <= 8'd31)) ||
           ((a == 8'd192) && (b == 8'd168));
  endfunction

endpackage

### hdl/ipdal_cell.sv
// ----------------------------------------------------------------------------
// ipdal_cell
// One list slot: holds an address, flags a match, shifts down on remove.
// ----------------------------------------------------------------------------
module ipdal_cell (
  input  logic                         clk,
  input  ipdal_pkg::cell_ctl_t         ctl,
  input  logic                         occupied,
  input  logic                         write_slot,
  input  logic                         rd_hit,
  input  logic                         hit_in,
  input  logic [ipdal_pkg::ADDR_W-1:0] nb_entry,
  input  logic [ipdal_pkg::ADDR_W-1:0] rd_in,
  output logic                         hit_out,
  output logic [ipdal_pkg::ADDR_W-1:0] entry_out,
  output logic [ipdal_pkg::ADDR_W-1:0] rd_out
);

  logic [ipdal_pkg::ADDR_W-1:0] entry_r;
  logic [ipdal_pkg::ADDR_W-1:0] entry_nxt;
  logic                         match_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.add_en && write_slot) begin
      entry_nxt = ctl.address;
    end else if (ctl.rm_en && (hit_in || match_r)) begin
      entry_nxt = nb_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp_en) begin
      match_r <= occupied && (entry_r == ctl.address);
    end
  end

  assign hit_out   = hit_in || match_r;
  assign entry_out = entry_r;
  assign rd_out    = (ctl.rd_en && rd_hit && occupied) ? (rd_in | entry_r) : rd_in;

endmodule

### hdl/ipdal_row.sv
// ----------------------------------------------------------------------------
// ipdal_row
// A chain of cells forming one packed list.
// ----------------------------------------------------------------------------
module ipdal_row #(
  parameter int MAX_ENTRIES = 16,
  parameter int CW          = 5
) (
  input  logic                         clk,
  input  ipdal_pkg::cell_ctl_t         ctl,
  input  logic [CW-1:0]                used,
  input  logic [ipdal_pkg::IDX_W-1:0]  entry_index,
  output logic                         found,
  output logic [ipdal_pkg::ADDR_W-1:0] rd_data
);

  localparam int XW = (CW > ipdal_pkg::IDX_W) ? CW : ipdal_pkg::IDX_W;

  logic                         hit_c [0:MAX_ENTRIES];
  logic [ipdal_pkg::ADDR_W-1:0] rd_c  [0:MAX_ENTRIES];
  logic [ipdal_pkg::ADDR_W-1:0] ent_c [0:MAX_ENTRIES];

  assign hit_c[0]           = 1'b0;
  assign rd_c[0]            = '0;
  assign ent_c[MAX_ENTRIES] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    ipdal_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CW'(i) < used),
      .write_slot (CW'(i) == used),
      .rd_hit     (XW'(i) == XW'(entry_index)),
      .hit_in     (hit_c[i]),
      .nb_entry   (ent_c[i+1]),
      .rd_in      (rd_c[i]),
      .hit_out    (hit_c[i+1]),
      .entry_out  (ent_c[i]),
      .rd_out     (rd_c[i+1])
    );
  end

  assign found   = hit_c[MAX_ENTRIES];
  assign rd_data = rd_c[MAX_ENTRIES];

endmodule

### hdl/ipv4_dual_allowlist_table.sv
// ----------------------------------------------------------------------------
// ipv4_dual_allowlist_table
// Admin and consumer IPv4 allowlists with lookup, add, remove and read.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per operation (opcode, list_select, address, entry_index).
//   out_* : one beat per operation (success, entry_count, entry_value).
//   cfg_* : register writes (edits_enabled, admin_private_only), always ready;
//           write only while no operation is in flight.
// Each list is a chain of MAX_ENTRIES cells. An operation runs in order:
// the accept cycle loads the request, the compare step registers each cell's
// match, and the update step resolves the match chain, shifts cells down on
// remove, writes the slot at the count on add, and loads the output register.
// in_ready is high only in the idle state ahead of the compare and update
// steps, so the next operation is taken only after the update step ends.
// A new input beat is taken while a result waits in the output register;
// if the receiver still stalls when the next result is ready, the block
// holds it in the update step until the output register frees.
// Reset clears both counts and sets both config bits to 1; entries need no
// clearing since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module ipv4_dual_allowlist_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ipdal_pkg::in_beat_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ipdal_pkg::out_beat_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipdal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                            cfg_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > ipdal_pkg::IDX_W) ? CW : ipdal_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXE  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  ipdal_pkg::in_beat_t  req_r;
  ipdal_pkg::out_beat_t out_r;
  logic                 out_valid_r;
  logic                 edits_r, priv_r;
  logic [CW-1:0]        admin_used_r, admin_used_nxt;
  logic [CW-1:0]        cons_used_r, cons_used_nxt;

  ipdal_pkg::cell_ctl_t         admin_ctl, cons_ctl;
  logic                         admin_found, cons_found, found;
  logic [ipdal_pkg::ADDR_W-1:0] admin_rd, cons_rd, rd_sel;
  logic [CW-1:0]                used_sel, used_after;
  logic                         exe_go, add_ok, rm_ok, rd_ok, success;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign exe_go   = (state_r == S_EXE) && (!out_valid_r || out_ready);
  assign used_sel = req_r.list_select ? cons_used_r : admin_used_r;
  assign found    = req_r.list_select ? cons_found : admin_found;
  assign rd_sel   = req_r.list_select ? cons_rd : admin_rd;

  always_comb begin
    add_ok = 1'b0;
    rm_ok  = 1'b0;
    rd_ok  = 1'b0;
    unique case (req_r.opcode)
      ipdal_pkg::OP_ADD: begin
        add_ok = edits_r && (used_sel < CW'(MAX_ENTRIES)) && !found &&
                 !((req_r.list_select == ipdal_pkg::LIST_ADMIN) && priv_r &&
                   !ipdal_pkg::addr_is_private(req_r.address));
      end
      ipdal_pkg::OP_REMOVE: rm_ok = edits_r && found;
      ipdal_pkg::OP_READ:   rd_ok = XW'(req_r.entry_index) < XW'(used_sel);
      default: ;
    endcase
  end

  always_comb begin
    success = found;
    unique case (req_r.opcode)
      ipdal_pkg::OP_ADD:    success = add_ok;
      ipdal_pkg::OP_REMOVE: success = rm_ok;
      ipdal_pkg::OP_READ:   success = rd_ok;
      default: ;
    endcase
  end

  always_comb begin
    used_after = used_sel;
    if (add_ok) begin
      used_after = used_sel + 1'b1;
    end else if (rm_ok) begin
      used_after = used_sel - 1'b1;
    end
  end

  always_comb begin
    admin_ctl.cmp_en  = (state_r == S_CMP);
    admin_ctl.add_en  = exe_go && add_ok && (req_r.list_select == ipdal_pkg::LIST_ADMIN);
    admin_ctl.rm_en   = exe_go && rm_ok && (req_r.list_select == ipdal_pkg::LIST_ADMIN);
    admin_ctl.rd_en   = (req_r.opcode == ipdal_pkg::OP_READ);
    admin_ctl.address = req_r.address;
    cons_ctl          = admin_ctl;
    cons_ctl.add_en   = exe_go && add_ok && (req_r.list_select == ipdal_pkg::LIST_CONSUMER);
    cons_ctl.rm_en    = exe_go && rm_ok && (req_r.list_select == ipdal_pkg::LIST_CONSUMER);
  end

  always_comb begin
    admin_used_nxt = admin_used_r;
    cons_used_nxt  = cons_used_r;
    if (exe_go) begin
      if (req_r.list_select == ipdal_pkg::LIST_CONSUMER) begin
        cons_used_nxt = used_after;
      end else begin
        admin_used_nxt = used_after;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_EXE;
      S_EXE:  if (exe_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  ipdal_row #(.MAX_ENTRIES(MAX_ENTRIES), .CW(CW)) u_admin (
    .clk         (clk),
    .ctl         (admin_ctl),
    .used        (admin_used_r),
    .entry_index (req_r.entry_index),
    .found       (admin_found),
    .rd_data     (admin_rd)
  );

  ipdal_row #(.MAX_ENTRIES(MAX_ENTRIES), .CW(CW)) u_consumer (
    .clk         (clk),
    .ctl         (cons_ctl),
    .used        (cons_used_r),
    .entry_index (req_r.entry_index),
    .found       (cons_found),
    .rd_data     (cons_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      admin_used_r <= '0;
      cons_used_r  <= '0;
      edits_r      <= 1'b1;
      priv_r       <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      admin_used_r <= admin_used_nxt;
      cons_used_r  <= cons_used_nxt;
      if (exe_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ipdal_pkg::CFG_EDITS_ENABLED:      edits_r <= cfg_data;
          ipdal_pkg::CFG_ADMIN_PRIVATE_ONLY: priv_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (exe_go) begin
      out_r.success     <= success;
      out_r.entry_count <= ipdal_pkg::COUNT_W'(used_after);
      out_r.entry_value <= rd_ok ? rd_sel : '0;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (admin_used_r <= CW'(MAX_ENTRIES)) && (cons_used_r <= CW'(MAX_ENTRIES)))
    else $error("list count above capacity");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    exe_go && add_ok && (req_r.list_select == ipdal_pkg::LIST_ADMIN)
    |=> admin_used_r == $past(admin_used_r) + 1'b1)
    else $error("admin add did not bump count");

  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CMP)
    else $error("accepted beat did not start compare");

endmodule
